/* design/pdcp_pkg.sv */
// ----------------------------------------------------------------------------
// pdcp_pkg
// Shared types and fixed-point constants for the pixel depth covariance
// propagation pipeline.
// ----------------------------------------------------------------------------
package pdcp_pkg;

    // field widths
    localparam int PIX_W      = 16;
    localparam int DEP_W      = 16;
    localparam int COV_W      = 32;
    localparam int RECIP_W    = 32;
    localparam int OUT_W      = 48;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // internal datapath widths, all exact
    localparam int M_W   = 49;   // 17b signed x 32b signed
    localparam int P_W   = 57;   // row of K*C
    localparam int Q_W   = 74;   // P x 17b signed
    localparam int S_W   = 82;   // entry of K*C*K^T
    localparam int E_W   = 64;   // product of two reciprocals
    localparam int HALF_W = 32;
    localparam int PP_W  = 64;   // unsigned partial product
    localparam int SH_W  = S_W - 2 * HALF_W;   // signed top slice of S
    localparam int PPS_W = HALF_W + 1 + SH_W;   // signed partial product
    localparam int Z0_W  = 98;
    localparam int Z1_W  = 84;
    localparam int X_W   = 148;

    // offset terms go from Q12.36 to Q12.44, the unit term is 2^12 in K
    localparam int OFF_SHIFT = 8;
    localparam int ONE_SHIFT = 12;

    // rounding positions for entries with zero, one or two unit factors
    localparam int RND_NONE = 88;
    localparam int RND_ONE  = 56;
    localparam int RND_TWO  = 24;

    // register stages from accept to result strobe
    localparam int PIPE_DEPTH = 9;

    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    // register reset values
    localparam logic [RECIP_W-1:0] RST_RECIP_FX = 32'd8388608;
    localparam logic [RECIP_W-1:0] RST_RECIP_FY = 32'd8388608;
    localparam logic [PIX_W-1:0]   RST_CENTER_X = 16'd5120;
    localparam logic [PIX_W-1:0]   RST_CENTER_Y = 16'd3840;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RECIP_FX = 2'd0,
        CFG_RECIP_FY = 2'd1,
        CFG_CENTER_X = 2'd2,
        CFG_CENTER_Y = 2'd3
    } t_cfg_idx;

    // how many unit (row 2) factors an output entry carries
    typedef enum logic [1:0] {
        SCALE_NONE = 2'd0,
        SCALE_ONE  = 2'd1,
        SCALE_TWO  = 2'd2
    } t_scale;

    typedef struct packed {
        logic [PIX_W-1:0]        pix_u;
        logic [PIX_W-1:0]        pix_v;
        logic [DEP_W-1:0]        depth_val;
        logic signed [COV_W-1:0] cov_00;
        logic signed [COV_W-1:0] cov_01;
        logic signed [COV_W-1:0] cov_02;
        logic signed [COV_W-1:0] cov_10;
        logic signed [COV_W-1:0] cov_11;
        logic signed [COV_W-1:0] cov_12;
        logic signed [COV_W-1:0] cov_20;
        logic signed [COV_W-1:0] cov_21;
        logic signed [COV_W-1:0] cov_22;
    } t_pix_item;

    typedef struct packed {
        logic signed [OUT_W-1:0] out_00;
        logic signed [OUT_W-1:0] out_01;
        logic signed [OUT_W-1:0] out_02;
        logic signed [OUT_W-1:0] out_10;
        logic signed [OUT_W-1:0] out_11;
        logic signed [OUT_W-1:0] out_12;
        logic signed [OUT_W-1:0] out_20;
        logic signed [OUT_W-1:0] out_21;
        logic signed [OUT_W-1:0] out_22;
        logic                    sat_flag;
    } t_cov_result;

endpackage

/* design/pdcp_scale_round.sv */
// ----------------------------------------------------------------------------
// pdcp_scale_round
// One output entry: exact 64b x 82b product split into six partial
// products, two summing stages, then round to nearest and saturate.
// ----------------------------------------------------------------------------
module pdcp_scale_round (
    input  logic                                 i_clk,
    input  logic [pdcp_pkg::E_W-1:0]             i_e,
    input  logic signed [pdcp_pkg::S_W-1:0]      i_s,
    input  pdcp_pkg::t_scale                     i_scale,
    output logic signed [pdcp_pkg::OUT_W-1:0]    o_val,
    output logic                                 o_sat
);

    localparam int HW = pdcp_pkg::HALF_W;

    logic [pdcp_pkg::PP_W-1:0]          r_ll, r_lm, r_hl, r_hm;
    logic signed [pdcp_pkg::PPS_W-1:0]  r_lh, r_hh;
    logic [pdcp_pkg::Z0_W-1:0]          r_z0, n_z0;
    logic signed [pdcp_pkg::Z1_W-1:0]   r_z1, n_z1;
    logic signed [pdcp_pkg::X_W-1:0]    r_x, n_x;
    logic signed [pdcp_pkg::OUT_W-1:0]  r_val, n_val;
    logic                               r_sat, n_sat;

    logic [HW-1:0]                      w_el, w_eh, w_sl, w_sm;
    logic signed [pdcp_pkg::SH_W-1:0]   w_shi;
    logic [pdcp_pkg::Z0_W-1:0]          w_rnd;
    logic signed [pdcp_pkg::X_W-1:0]    w_shr;
    logic [pdcp_pkg::X_W-pdcp_pkg::OUT_W:0] w_top;
    logic                               w_fits;

    assign w_el  = i_e[HW-1:0];
    assign w_eh  = i_e[2*HW-1:HW];
    assign w_sl  = i_s[HW-1:0];
    assign w_sm  = i_s[2*HW-1:HW];
    assign w_shi = i_s[pdcp_pkg::S_W-1:2*HW];

    // partial products
    always_ff @(posedge i_clk) begin
        r_ll <= w_el * w_sl;
        r_lm <= w_el * w_sm;
        r_hl <= w_eh * w_sl;
        r_hm <= w_eh * w_sm;
        r_lh <= $signed({1'b0, w_el}) * w_shi;
        r_hh <= $signed({1'b0, w_eh}) * w_shi;
    end

    // rounding half-unit, folded into the low sum
    always_comb begin
        unique case (i_scale)
            pdcp_pkg::SCALE_NONE: w_rnd = pdcp_pkg::Z0_W'(1) << (pdcp_pkg::RND_NONE - 1);
            pdcp_pkg::SCALE_ONE:  w_rnd = pdcp_pkg::Z0_W'(1) << (pdcp_pkg::RND_ONE - 1);
            pdcp_pkg::SCALE_TWO:  w_rnd = pdcp_pkg::Z0_W'(1) << (pdcp_pkg::RND_TWO - 1);
            default:              w_rnd = '0;
        endcase
    end

    always_comb begin
        n_z0 = pdcp_pkg::Z0_W'(r_ll)
             + ((pdcp_pkg::Z0_W'(r_lm) + pdcp_pkg::Z0_W'(r_hl)) << HW)
             + w_rnd;
        n_z1 = $signed(pdcp_pkg::Z1_W'(r_hm))
             + pdcp_pkg::Z1_W'(r_lh)
             + (pdcp_pkg::Z1_W'(r_hh) <<< HW);
        n_x  = $signed(pdcp_pkg::X_W'(r_z0))
             + (pdcp_pkg::X_W'(r_z1) <<< (2 * HW));
    end

    always_ff @(posedge i_clk) begin
        r_z0 <= n_z0;
        r_z1 <= n_z1;
        r_x  <= n_x;
    end

    always_comb begin
        unique case (i_scale)
            pdcp_pkg::SCALE_NONE: w_shr = r_x >>> pdcp_pkg::RND_NONE;
            pdcp_pkg::SCALE_ONE:  w_shr = r_x >>> pdcp_pkg::RND_ONE;
            pdcp_pkg::SCALE_TWO:  w_shr = r_x >>> pdcp_pkg::RND_TWO;
            default:              w_shr = r_x;
        endcase
        w_top  = w_shr[pdcp_pkg::X_W-1:pdcp_pkg::OUT_W-1];
        w_fits = (&w_top) | ~(|w_top);
        n_sat  = ~w_fits;
        if (w_fits) begin
            n_val = w_shr[pdcp_pkg::OUT_W-1:0];
        end else if (r_x[pdcp_pkg::X_W-1]) begin
            n_val = pdcp_pkg::OUT_MIN;
        end else begin
            n_val = pdcp_pkg::OUT_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        r_sat <= n_sat;
    end

    assign o_val = r_val;
    assign o_sat = r_sat;

endmodule

/* design/pixel_depth_covariance_propagation.sv */
// ----------------------------------------------------------------------------
// pixel_depth_covariance_propagation
// Propagates a 3x3 screen covariance through the pixel/depth Jacobian,
// returning J*C*J^T as nine rounded, saturated Q32.16 entries.
// ----------------------------------------------------------------------------
// Fully pipelined: one transaction may be started every clock cycle. Its
// result is on o_result, with o_done high, once it has passed every
// register stage after the edge that accepted it (start high, busy low).
// The nine register stages are the input capture,
// three multiply levels (depth/offset times covariance, that row times
// depth/offset, then the reciprocal focal product), a summing stage after
// each of the first two, two summing stages that assemble the wide product,
// and the round/saturate output register. There is no backpressure: o_done
// is a strobe and the receiver must take the result in that cycle. busy is
// only high while reset is held. Configuration writes are taken every cycle
// outside reset and must only be issued while no transaction is in flight.
// ----------------------------------------------------------------------------
module pixel_depth_covariance_propagation (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // transaction start
    input  logic                                 start,
    output logic                                 busy,
    input  pdcp_pkg::t_pix_item                  i_item,
    // result strobe
    output logic                                 o_done,
    output pdcp_pkg::t_cov_result                o_result,
    // configuration write channel
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [pdcp_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [pdcp_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int COV_W = pdcp_pkg::COV_W;
    localparam int PIX_W = pdcp_pkg::PIX_W;
    localparam int DEP_W = pdcp_pkg::DEP_W;
    localparam int M_W   = pdcp_pkg::M_W;
    localparam int P_W   = pdcp_pkg::P_W;
    localparam int Q_W   = pdcp_pkg::Q_W;
    localparam int S_W   = pdcp_pkg::S_W;
    localparam int E_W   = pdcp_pkg::E_W;
    localparam int OUT_W = pdcp_pkg::OUT_W;
    localparam int DEPTH = pdcp_pkg::PIPE_DEPTH;

    // configuration registers
    logic [pdcp_pkg::RECIP_W-1:0] r_rfx, r_rfy;
    logic [PIX_W-1:0]             r_cx, r_cy;

    // reciprocal products, refreshed every cycle from the config registers
    logic [E_W-1:0] r_exx, r_exy, r_eyy;

    logic             w_accept;
    logic [DEPTH-1:0] r_vld;

    logic signed [COV_W-1:0] w_cov [3][3];
    logic [PIX_W-1:0]        w_du, w_dv;

    // stage 1: captured item with absolute offsets from the principal point
    logic signed [COV_W-1:0] r1_cov [3][3];
    logic [DEP_W-1:0]        r1_dep;
    logic [PIX_W-1:0]        r1_du, r1_dv;

    // stage 2: depth and offset products against the covariance rows
    logic signed [M_W-1:0]   r2_mdep [2][3];
    logic signed [M_W-1:0]   r2_moff [2][3];
    logic signed [COV_W-1:0] r2_c2 [3];
    logic [DEP_W-1:0]        r2_dep;
    logic [PIX_W-1:0]        r2_du, r2_dv;

    // stage 3: P = K*C
    logic signed [P_W-1:0]   r3_p [3][3];
    logic [DEP_W-1:0]        r3_dep;
    logic [PIX_W-1:0]        r3_du, r3_dv;

    // stage 4: products of P against the columns of K^T
    logic signed [Q_W-1:0]   r4_qa [3];
    logic signed [Q_W-1:0]   r4_qb [3];
    logic signed [Q_W-1:0]   r4_qc [3];
    logic signed [Q_W-1:0]   r4_qd [3];
    logic signed [P_W-1:0]   r4_p2 [3];

    // stage 5: S = K*C*K^T
    logic signed [S_W-1:0]   r5_s [3][3];

    logic [E_W-1:0]          w_e [3][3];
    logic signed [OUT_W-1:0] w_val [3][3];
    logic [8:0]              w_sat;

    // no backpressure, only reset holds off new transactions
    assign busy        = ~i_rst_n;
    assign o_cfg_ready = i_rst_n;
    assign w_accept    = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rfx <= pdcp_pkg::RST_RECIP_FX;
            r_rfy <= pdcp_pkg::RST_RECIP_FY;
            r_cx  <= pdcp_pkg::RST_CENTER_X;
            r_cy  <= pdcp_pkg::RST_CENTER_Y;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (pdcp_pkg::t_cfg_idx'(i_cfg_index))
                pdcp_pkg::CFG_RECIP_FX: r_rfx <= i_cfg_data;
                pdcp_pkg::CFG_RECIP_FY: r_rfy <= i_cfg_data;
                pdcp_pkg::CFG_CENTER_X: r_cx  <= i_cfg_data[PIX_W-1:0];
                pdcp_pkg::CFG_CENTER_Y: r_cy  <= i_cfg_data[PIX_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // config must be stable whenever a transaction reaches these; the block does not enforce it
    always_ff @(posedge i_clk) begin
        r_exx <= r_rfx * r_rfx;
        r_exy <= r_rfx * r_rfy;
        r_eyy <= r_rfy * r_rfy;
    end

    // valid bits travel alongside the data stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[DEPTH-2:0], w_accept};
        end
    end

    always_comb begin
        w_cov[0][0] = i_item.cov_00;
        w_cov[0][1] = i_item.cov_01;
        w_cov[0][2] = i_item.cov_02;
        w_cov[1][0] = i_item.cov_10;
        w_cov[1][1] = i_item.cov_11;
        w_cov[1][2] = i_item.cov_12;
        w_cov[2][0] = i_item.cov_20;
        w_cov[2][1] = i_item.cov_21;
        w_cov[2][2] = i_item.cov_22;
        // pixels left of or above the principal point use the magnitude
        w_du = (i_item.pix_u >= r_cx) ? (i_item.pix_u - r_cx) : (r_cx - i_item.pix_u);
        w_dv = (i_item.pix_v >= r_cy) ? (i_item.pix_v - r_cy) : (r_cy - i_item.pix_v);
    end

    // stage 1
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            for (int l = 0; l < 3; l++) begin
                r1_cov[k][l] <= w_cov[k][l];
            end
        end
        r1_dep <= i_item.depth_val;
        r1_du  <= w_du;
        r1_dv  <= w_dv;
    end

    // stage 2: row i of K is [dep, 0, off<<8] / [0, dep, off<<8] / [0, 0, 2^12]
    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 3; l++) begin
            r2_mdep[0][l] <= $signed({1'b0, r1_dep}) * r1_cov[0][l];
            r2_mdep[1][l] <= $signed({1'b0, r1_dep}) * r1_cov[1][l];
            r2_moff[0][l] <= $signed({1'b0, r1_du}) * r1_cov[2][l];
            r2_moff[1][l] <= $signed({1'b0, r1_dv}) * r1_cov[2][l];
            r2_c2[l]      <= r1_cov[2][l];
        end
        r2_dep <= r1_dep;
        r2_du  <= r1_du;
        r2_dv  <= r1_dv;
    end

    // stage 3
    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 3; l++) begin
            for (int i = 0; i < 2; i++) begin
                r3_p[i][l] <= P_W'(r2_mdep[i][l])
                            + (P_W'(r2_moff[i][l]) <<< pdcp_pkg::OFF_SHIFT);
            end
            r3_p[2][l] <= P_W'(r2_c2[l]) <<< pdcp_pkg::ONE_SHIFT;
        end
        r3_dep <= r2_dep;
        r3_du  <= r2_du;
        r3_dv  <= r2_dv;
    end

    // stage 4
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r4_qa[i] <= r3_p[i][0] * $signed({1'b0, r3_dep});
            r4_qb[i] <= r3_p[i][2] * $signed({1'b0, r3_du});
            r4_qc[i] <= r3_p[i][1] * $signed({1'b0, r3_dep});
            r4_qd[i] <= r3_p[i][2] * $signed({1'b0, r3_dv});
            r4_p2[i] <= r3_p[i][2];
        end
    end

    // stage 5
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r5_s[i][0] <= S_W'(r4_qa[i]) + (S_W'(r4_qb[i]) <<< pdcp_pkg::OFF_SHIFT);
            r5_s[i][1] <= S_W'(r4_qc[i]) + (S_W'(r4_qd[i]) <<< pdcp_pkg::OFF_SHIFT);
            r5_s[i][2] <= S_W'(r4_p2[i]) <<< pdcp_pkg::ONE_SHIFT;
        end
    end

    // outer factors D_i * D_j with D = (1/fx, 1/fy, 1); the unit row is
    // accounted for by the rounding position instead
    always_comb begin
        w_e[0][0] = r_exx;
        w_e[0][1] = r_exy;
        w_e[1][0] = r_exy;
        w_e[1][1] = r_eyy;
        w_e[0][2] = E_W'(r_rfx);
        w_e[2][0] = E_W'(r_rfx);
        w_e[1][2] = E_W'(r_rfy);
        w_e[2][1] = E_W'(r_rfy);
        w_e[2][2] = E_W'(1);
    end

    // stages 6 to 9: one scale/round unit per output entry
    for (genvar gi = 0; gi < 3; gi++) begin : g_row
        for (genvar gj = 0; gj < 3; gj++) begin : g_col
            localparam pdcp_pkg::t_scale SC =
                (gi == 2 && gj == 2) ? pdcp_pkg::SCALE_TWO :
                (gi == 2 || gj == 2) ? pdcp_pkg::SCALE_ONE : pdcp_pkg::SCALE_NONE;

            pdcp_scale_round u_entry (
                .i_clk   (i_clk),
                .i_e     (w_e[gi][gj]),
                .i_s     (r5_s[gi][gj]),
                .i_scale (SC),
                .o_val   (w_val[gi][gj]),
                .o_sat   (w_sat[gi*3+gj])
            );
        end
    end

    assign o_done            = r_vld[DEPTH-1];
    assign o_result.out_00   = w_val[0][0];
    assign o_result.out_01   = w_val[0][1];
    assign o_result.out_02   = w_val[0][2];
    assign o_result.out_10   = w_val[1][0];
    assign o_result.out_11   = w_val[1][1];
    assign o_result.out_12   = w_val[1][2];
    assign o_result.out_20   = w_val[2][0];
    assign o_result.out_21   = w_val[2][1];
    assign o_result.out_22   = w_val[2][2];
    assign o_result.sat_flag = |w_sat;

endmodule

/* design/pdcp_checker.sv */
// ----------------------------------------------------------------------------
// pdcp_port_checks
// Port-level checks for the covariance propagation pipeline, bound to the
// top level.
// ----------------------------------------------------------------------------
module pdcp_port_checks (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    input  logic                   busy,
    input  pdcp_pkg::t_pix_item    i_item,
    input  logic                   o_done,
    input  pdcp_pkg::t_cov_result  o_result
);

    localparam int DEPTH = pdcp_pkg::PIPE_DEPTH;

    logic w_any_bound;

    // some entry sits on a saturation bound
    always_comb begin
        w_any_bound = (o_result.out_00 == pdcp_pkg::OUT_MAX)
                   || (o_result.out_00 == pdcp_pkg::OUT_MIN)
                   || (o_result.out_01 == pdcp_pkg::OUT_MAX)
                   || (o_result.out_01 == pdcp_pkg::OUT_MIN)
                   || (o_result.out_02 == pdcp_pkg::OUT_MAX)
                   || (o_result.out_02 == pdcp_pkg::OUT_MIN)
                   || (o_result.out_10 == pdcp_pkg::OUT_MAX)
                   || (o_result.out_10 == pdcp_pkg::OUT_MIN)
                   || (o_result.out_11 == pdcp_pkg::OUT_MAX)
                   || (o_result.out_11 == pdcp_pkg::OUT_MIN)
                   || (o_result.out_12 == pdcp_pkg::OUT_MAX)
                   || (o_result.out_12 == pdcp_pkg::OUT_MIN)
                   || (o_result.out_20 == pdcp_pkg::OUT_MAX)
                   || (o_result.out_20 == pdcp_pkg::OUT_MIN)
                   || (o_result.out_21 == pdcp_pkg::OUT_MAX)
                   || (o_result.out_21 == pdcp_pkg::OUT_MIN)
                   || (o_result.out_22 == pdcp_pkg::OUT_MAX)
                   || (o_result.out_22 == pdcp_pkg::OUT_MIN);
    end

    // every accepted transaction produces its strobe at the end of the pipeline
    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##DEPTH o_done)
        else $error("accepted transaction did not complete on time");

    // no strobe without a transaction accepted at the head of the pipeline
    a_done_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, DEPTH))
        else $error("result strobe without a matching transaction");

    // the unit row of the jacobian passes cov_22 straight through
    a_corner_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.out_22 ==
            {{(pdcp_pkg::OUT_W-pdcp_pkg::COV_W){$past(i_item.cov_22[pdcp_pkg::COV_W-1],
            DEPTH)}}, $past(i_item.cov_22, DEPTH)}))
        else $error("corner entry does not match its covariance input");

    // a saturation flag means some entry was clamped to a bound
    a_sat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.sat_flag) |-> w_any_bound)
        else $error("saturation flagged but no entry at a bound");

endmodule

bind pixel_depth_covariance_propagation pdcp_port_checks u_pdcp_port_checks (.*);
